// File: hw/rtl/b2rbc_pkg.sv
// Package for the BLAKE2s round block cipher: sequencer types, microcode and sigma schedule.
package b2rbc_pkg;

  localparam int ROUNDS   = 10;
  localparam int RND_W    = 4;
  localparam int PC_W     = 5;
  localparam int IN_TDW   = 72;
  localparam int OUT_TDW  = 40;

  typedef logic [PC_W-1:0]  pc_t;
  typedef logic [RND_W-1:0] rnd_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_FETCH,
    OP_GA,
    OP_GB,
    OP_DIAG,
    OP_UNDIAG,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_ROUND,
    BR_EMIT,
    BR_START
  } br_t;

  typedef struct packed {
    op_t        op;
    logic       rd_en;
    logic [3:0] rd_j;
    br_t        br;
  } ctl_t;

  localparam pc_t PC_START  = 5'd0;
  localparam pc_t PC_UNDIAG = 5'd18;
  localparam pc_t PC_EMIT   = 5'd19;
  localparam pc_t PC_IDLE   = 5'd20;

  localparam rnd_t LAST_ROUND = RND_W'(ROUNDS - 1);

  // one row per round, message index j in nibble j
  localparam logic [63:0] SIGMA [10] = '{
    64'hFEDCBA9876543210,
    64'h357B20C16DF984AE,
    64'h491763EADF250C8B,
    64'h8F04A562EBCD1397,
    64'hD386CB1EFA427509,
    64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C,
    64'hA2684F05931CE7BD,
    64'h5A417D2C803B9EF6,
    64'h0DC3E9BF5167482A
  };

  function automatic logic [3:0] sigma(input rnd_t r, input logic [3:0] j);
    logic [63:0] row;
    row = 64'd0;
    if (r < rnd_t'(10)) begin
      row = SIGMA[r];
    end
    return row[{j, 2'b00} +: 4];
  endfunction

  // control store: one word per step of a round, then output and idle
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '{op: OP_IDLE, rd_en: 1'b0, rd_j: 4'd0, br: BR_START};
    case (pc)
      5'd0:  c = '{op: OP_FETCH,  rd_en: 1'b1, rd_j: 4'd0,  br: BR_NEXT};
      5'd1:  c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd1,  br: BR_NEXT};
      5'd2:  c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd2,  br: BR_NEXT};
      5'd3:  c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd3,  br: BR_NEXT};
      5'd4:  c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd4,  br: BR_NEXT};
      5'd5:  c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd5,  br: BR_NEXT};
      5'd6:  c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd6,  br: BR_NEXT};
      5'd7:  c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd7,  br: BR_NEXT};
      5'd8:  c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd8,  br: BR_NEXT};
      5'd9:  c = '{op: OP_DIAG,   rd_en: 1'b0, rd_j: 4'd0,  br: BR_NEXT};
      5'd10: c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd9,  br: BR_NEXT};
      5'd11: c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd10, br: BR_NEXT};
      5'd12: c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd11, br: BR_NEXT};
      5'd13: c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd12, br: BR_NEXT};
      5'd14: c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd13, br: BR_NEXT};
      5'd15: c = '{op: OP_GB,     rd_en: 1'b1, rd_j: 4'd14, br: BR_NEXT};
      5'd16: c = '{op: OP_GA,     rd_en: 1'b1, rd_j: 4'd15, br: BR_NEXT};
      5'd17: c = '{op: OP_GB,     rd_en: 1'b0, rd_j: 4'd0,  br: BR_NEXT};
      5'd18: c = '{op: OP_UNDIAG, rd_en: 1'b0, rd_j: 4'd0,  br: BR_ROUND};
      5'd19: c = '{op: OP_EMIT,   rd_en: 1'b0, rd_j: 4'd0,  br: BR_EMIT};
      default: c = '{op: OP_IDLE, rd_en: 1'b0, rd_j: 4'd0,  br: BR_START};
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/blake2s_round_block_cipher.sv
// A request with index 15 starts the rounds, run by microcode on the single half-G unit;
// the results then follow, one result per cycle while out_tready stays high.
// Throughput: one load request per cycle while idle; none is taken during rounds or output.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// The key and block stores are not cleared and hold nothing defined until written.
module blake2s_round_block_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [b2rbc_pkg::IN_TDW-1:0]  in_tdata,   // word_index[3:0], key_word[35:4], block_word[67:36]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [b2rbc_pkg::OUT_TDW-1:0] out_tdata,  // out_index[3:0], out_word[35:4]
  output logic                          out_tlast
);

  b2rbc_pkg::pc_t  pc_r, pc_nxt;
  b2rbc_pkg::rnd_t round_r, round_nxt;
  b2rbc_pkg::ctl_t ctl;
  logic [3:0]      emit_cnt_r, emit_cnt_nxt;

  logic [31:0] v_r [16];
  logic [31:0] v_nxt [16];
  logic [31:0] key_mem [16];
  logic [31:0] key_q_r;
  logic [3:0]  key_addr;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [3:0]  out_index_r, out_index_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;

  logic [3:0]  in_idx;
  logic [31:0] in_key;
  logic [31:0] in_block;
  logic        in_acc;
  logic        emit_go;
  logic        is_gb;

  logic [31:0] ga, gb, gc, gd;
  logic [31:0] na, nb, nc, nd;
  logic [31:0] dx, bx;

  assign in_idx   = in_tdata[3:0];
  assign in_key   = in_tdata[35:4];
  assign in_block = in_tdata[67:36];

  assign ctl       = b2rbc_pkg::ucode(pc_r);
  assign in_tready = (ctl.op == b2rbc_pkg::OP_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign emit_go   = (ctl.op == b2rbc_pkg::OP_EMIT) && (!out_tvalid_r || out_tready);
  assign is_gb     = (ctl.op == b2rbc_pkg::OP_GB);
  assign key_addr  = b2rbc_pkg::sigma(round_r, ctl.rd_j);

  // key store: written by load requests, one registered read port for message words
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_mem[in_idx] <= in_key;
    end
    if (ctl.rd_en) begin
      key_q_r <= key_mem[key_addr];
    end
  end

  // half of G on column zero; rotations pick the first or second half
  always_comb begin
    ga = v_r[0];
    gb = v_r[4];
    gc = v_r[8];
    gd = v_r[12];
    na = ga + gb + key_q_r;
    dx = gd ^ na;
    nd = is_gb ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    nc = gc + nd;
    bx = gb ^ nc;
    nb = is_gb ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
  end

  // sequencer: next step
  always_comb begin
    pc_nxt       = pc_r;
    round_nxt    = round_r;
    emit_cnt_nxt = emit_cnt_r;
    case (ctl.br)
      b2rbc_pkg::BR_NEXT: begin
        pc_nxt = pc_r + b2rbc_pkg::pc_t'(1);
      end
      b2rbc_pkg::BR_ROUND: begin
        if (round_r == b2rbc_pkg::LAST_ROUND) begin
          pc_nxt    = b2rbc_pkg::PC_EMIT;
          round_nxt = '0;
        end else begin
          pc_nxt    = b2rbc_pkg::PC_START;
          round_nxt = round_r + b2rbc_pkg::rnd_t'(1);
        end
      end
      b2rbc_pkg::BR_EMIT: begin
        if (emit_go) begin
          emit_cnt_nxt = emit_cnt_r + 4'd1;
          if (emit_cnt_r == 4'd15) begin
            pc_nxt = b2rbc_pkg::PC_IDLE;
          end
        end
      end
      b2rbc_pkg::BR_START: begin
        if (in_acc && (in_idx == 4'd15)) begin
          pc_nxt       = b2rbc_pkg::PC_START;
          round_nxt    = '0;
          emit_cnt_nxt = 4'd0;
        end
      end
      default: begin
        pc_nxt = b2rbc_pkg::PC_IDLE;
      end
    endcase
  end

  // datapath driven by the control word
  always_comb begin
    v_nxt = v_r;
    case (ctl.op)
      b2rbc_pkg::OP_IDLE: begin
        if (in_acc) begin
          v_nxt[in_idx] = in_block;
        end
      end
      b2rbc_pkg::OP_GA: begin
        v_nxt[0]  = na;
        v_nxt[4]  = nb;
        v_nxt[8]  = nc;
        v_nxt[12] = nd;
      end
      b2rbc_pkg::OP_GB: begin
        // write back and rotate every row left so the next column sits at zero
        for (int k = 0; k < 4; k++) begin
          for (int i = 0; i < 3; i++) begin
            v_nxt[4*k+i] = v_r[4*k+i+1];
          end
        end
        v_nxt[3]  = na;
        v_nxt[7]  = nb;
        v_nxt[11] = nc;
        v_nxt[15] = nd;
      end
      b2rbc_pkg::OP_DIAG: begin
        for (int k = 0; k < 4; k++) begin
          for (int i = 0; i < 4; i++) begin
            v_nxt[4*k+i] = v_r[4*k+((i+k)&3)];
          end
        end
      end
      b2rbc_pkg::OP_UNDIAG: begin
        for (int k = 0; k < 4; k++) begin
          for (int i = 0; i < 4; i++) begin
            v_nxt[4*k+i] = v_r[4*k+((i+4-k)&3)];
          end
        end
      end
      b2rbc_pkg::OP_EMIT: begin
        // shift the whole state by one word; sixteen shifts restore it
        if (emit_go) begin
          for (int i = 0; i < 16; i++) begin
            v_nxt[i] = v_r[(i+1)&15];
          end
        end
      end
      default: begin
        v_nxt = v_r;
      end
    endcase
  end

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_index_nxt  = out_index_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (emit_go) begin
      out_tvalid_nxt = 1'b1;
      out_index_nxt  = emit_cnt_r;
      out_word_nxt   = v_r[0];
      out_last_nxt   = (emit_cnt_r == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= b2rbc_pkg::PC_IDLE;
      round_r      <= '0;
      emit_cnt_r   <= 4'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      round_r      <= round_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    out_index_r <= out_index_nxt;
    out_word_r  <= out_word_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_word_r, out_index_r};
  assign out_tlast  = out_last_r;

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= b2rbc_pkg::PC_IDLE)
    else $error("step counter beyond control store");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= b2rbc_pkg::LAST_ROUND)
    else $error("round counter beyond last round");

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[3:0] == 4'd15) |=> (pc_r == b2rbc_pkg::PC_START))
    else $error("start request did not launch the rounds");

  // any word before the last is shown only while the sequencer is still emitting
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (pc_r == b2rbc_pkg::PC_EMIT))
    else $error("word shown while sequencer not emitting");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tdata[3:0] == 4'($past(out_tdata[3:0]) + 4'd1)))
    else $error("result index did not advance by one");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the BLAKE2s round block cipher stream interface.
`timescale 1ns / 100ps

module testbench;

  localparam logic [3:0] START_INDEX    = 4'd15;
  localparam int         TOTAL_REQUESTS = 520;
  localparam int         CALM_FROM      = 440;
  localparam int         TAIL_CYCLES    = 220;

  // message word order per round
  localparam logic [3:0] MSG_ORDER [10][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
  };

  // columns first, then diagonals: a, b, c, d
  localparam logic [3:0] MIX_LANES [8][4] = '{
    '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
  };

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] word;
    logic        last;
  } cipher_word_t;

  class round_cipher_sb;
    logic [31:0]  key_words [16];
    logic [31:0]  state_words [16];
    cipher_word_t expected_words [$];
    int           mismatches;
    int           checked;
    int           starts;

    function new();
      mismatches = 0;
      checked    = 0;
      starts     = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int unsigned s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void mix_g(int g, logic [31:0] x, logic [31:0] y);
      logic [31:0] a, b, c, d;
      a = state_words[MIX_LANES[g][0]];
      b = state_words[MIX_LANES[g][1]];
      c = state_words[MIX_LANES[g][2]];
      d = state_words[MIX_LANES[g][3]];
      a = a + b + x;
      d = rotr(d ^ a, 16);
      c = c + d;
      b = rotr(b ^ c, 12);
      a = a + b + y;
      d = rotr(d ^ a, 8);
      c = c + d;
      b = rotr(b ^ c, 7);
      state_words[MIX_LANES[g][0]] = a;
      state_words[MIX_LANES[g][1]] = b;
      state_words[MIX_LANES[g][2]] = c;
      state_words[MIX_LANES[g][3]] = d;
    endfunction

    // store the words; on a start run the rounds in place and queue all sixteen words
    function void note_request(logic [3:0] idx, logic [31:0] key, logic [31:0] blk);
      cipher_word_t w;
      key_words[idx]   = key;
      state_words[idx] = blk;
      if (idx != START_INDEX) return;
      starts++;
      for (int r = 0; r < b2rbc_pkg::ROUNDS; r++) begin
        for (int g = 0; g < 8; g++) begin
          mix_g(g, key_words[MSG_ORDER[r % 10][2 * g]], key_words[MSG_ORDER[r % 10][2 * g + 1]]);
        end
      end
      for (int i = 0; i < 16; i++) begin
        w.idx  = 4'(i);
        w.word = state_words[i];
        w.last = (i == 15);
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(logic [3:0] idx, logic [31:0] word, logic last);
      cipher_word_t exp_w;
      checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word: index %0d word %08h last %b",
                   $time, idx, word, last);
        return;
      end
      exp_w = expected_words.pop_front();
      if (idx !== exp_w.idx || word !== exp_w.word || last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected index %0d word %08h last %b, got %0d %08h %b",
                   $time, exp_w.idx, exp_w.word, exp_w.last, idx, word, last);
      end
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [b2rbc_pkg::IN_TDW-1:0]  in_tdata   = '0;  // word_index[3:0], key_word[35:4], block_word[67:36]
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [b2rbc_pkg::OUT_TDW-1:0] out_tdata;        // out_index[3:0], out_word[35:4]
  logic                          out_tlast;

  round_cipher_sb sb;
  logic           calm    = 1'b0;
  int             rx_hold = 0;
  int             sent    = 0;

  blake2s_round_block_cipher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // hold the request until it is taken
  task automatic send_request(input logic [3:0] idx, input logic [31:0] key,
                              input logic [31:0] blk);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, blk, key, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(idx, key, blk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin : rx_stall
    logic ready_next;
    ready_next = 1'b1;
    if (!calm) begin
      if (rx_hold > 0) begin
        rx_hold--;
        ready_next = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_hold    = $urandom_range(0, 6);
        ready_next = 1'b0;
      end
    end
    out_tready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_word(out_tdata[3:0], out_tdata[35:4], out_tlast);
  end

  initial begin : main_seq
    int order [15];
    int pick;
    int n;
    int j;
    int tmp;
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // the first block writes every entry, so nothing undefined is ever read
    for (int i = 0; i < 16; i++) send_request(4'(i), 32'h0, 32'h0);
    // start again on the kept state, then reload single words, one twice
    send_request(START_INDEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(4'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(4'd0, 32'h0000_0001, 32'h7FFF_FFFF);
    send_request(4'd14, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(START_INDEX, 32'h0, 32'hFFFF_FFFF);
    drain();

    while (sent < TOTAL_REQUESTS) begin
      calm = (sent >= CALM_FROM);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        for (int i = 0; i < 15; i++) order[i] = i;
        if ($urandom_range(0, 1) == 1) begin
          for (int i = 14; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
        end
        for (int i = 0; i < 15; i++) send_request(4'(order[i]), rand_word(), rand_word());
        send_request(START_INDEX, rand_word(), rand_word());
      end else if (pick < 8) begin
        n = $urandom_range(0, 6);
        repeat (n) send_request(4'($urandom_range(0, 14)), rand_word(), rand_word());
        send_request(START_INDEX, rand_word(), rand_word());
      end else if (pick < 9) begin
        n = $urandom_range(1, 5);
        repeat (n) send_request(4'($urandom_range(0, 15)), rand_word(), rand_word());
      end else begin
        drain();
        send_request(START_INDEX, rand_word(), rand_word());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("testbench: %0d requests sent, %0d block starts, %0d words checked",
             sent, sb.starts, sb.checked);
    $display("testbench: full, partial, repeated and scattered loads; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("testbench: timeout, %0d words still expected", sb.expected_words.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule
